FILE: src/bfth_pkg.sv
// Shared types, constants and hash step functions for the three-hash Bloom filter.
`timescale 1ns / 1ps
package bfth_pkg;

  localparam int HashW = 64;
  localparam int ByteW = 8;
  localparam int CntW  = 13;
  localparam int NumHash = 3;
  localparam int MinBits = 8;

  localparam logic [HashW-1:0] DjbSeed = 64'd5381;
  localparam logic [HashW-1:0] FnvSeed = 64'hCBF2_9CE4_8422_2325;
  localparam logic [HashW-1:0] RotSeed = 64'd0;
  localparam logic [CntW-1:0]  BitCountReset = 13'd4096;

  typedef enum logic [1:0] {
    MS_IDLE,
    MS_RUN,
    MS_HOLD
  } mod_state_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_FINISH
  } store_state_e;

  // handoff from the remainder unit to the bit store
  typedef struct packed {
    logic valid;
    logic op;
  } job_ctl_t;

  function automatic logic [HashW-1:0] djb_step(logic [HashW-1:0] h, logic [ByteW-1:0] b);
    djb_step = (h << 5) + h + {{(HashW-ByteW){1'b0}}, b};
  endfunction

  // (h ^ b) * 0x100000001B3, prime written as shifts: 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2 + 1
  function automatic logic [HashW-1:0] fnv_step(logic [HashW-1:0] h, logic [ByteW-1:0] b);
    logic [HashW-1:0] x;
    x = h ^ {{(HashW-ByteW){1'b0}}, b};
    fnv_step = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  function automatic logic [HashW-1:0] rot_step(logic [HashW-1:0] h, logic [ByteW-1:0] b);
    rot_step = (h << 7) ^ (h >> 3) ^ {{(HashW-ByteW){1'b0}}, b};
  endfunction

endpackage

FILE: src/bfth_hash.sv
// Running hash registers, updated once per key byte.
`timescale 1ns / 1ps
module bfth_hash (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  logic [bfth_pkg::ByteW-1:0]             key_byte_i,
  input  logic                                   key_last_i,
  output logic [bfth_pkg::NumHash-1:0][bfth_pkg::HashW-1:0] hash_o
);

  logic [bfth_pkg::HashW-1:0] djb_q, djb_d;
  logic [bfth_pkg::HashW-1:0] fnv_q, fnv_d;
  logic [bfth_pkg::HashW-1:0] rot_q, rot_d;

  always_comb begin
    djb_d = bfth_pkg::djb_step(djb_q, key_byte_i);
    fnv_d = bfth_pkg::fnv_step(fnv_q, key_byte_i);
    rot_d = bfth_pkg::rot_step(rot_q, key_byte_i);
  end

  assign hash_o[0] = djb_d;
  assign hash_o[1] = fnv_d;
  assign hash_o[2] = rot_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      djb_q <= bfth_pkg::DjbSeed;
      fnv_q <= bfth_pkg::FnvSeed;
      rot_q <= bfth_pkg::RotSeed;
    end else if (accept_i) begin
      if (key_last_i) begin
        djb_q <= bfth_pkg::DjbSeed;
        fnv_q <= bfth_pkg::FnvSeed;
        rot_q <= bfth_pkg::RotSeed;
      end else begin
        djb_q <= djb_d;
        fnv_q <= fnv_d;
        rot_q <= rot_d;
      end
    end
  end

endmodule

FILE: src/bfth_mod.sv
// Three-lane bit-serial remainder unit: hash mod effective bit count.
`timescale 1ns / 1ps
module bfth_mod #(
  parameter int MAX_BITS = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic                                   op_i,
  input  logic [bfth_pkg::CntW-1:0]              filter_len_i,
  input  logic [bfth_pkg::NumHash-1:0][bfth_pkg::HashW-1:0] hash_i,
  output logic                                   ready_o,
  output bfth_pkg::job_ctl_t                     job_o,
  output logic [bfth_pkg::NumHash-1:0][$clog2(MAX_BITS)-1:0] idx_o,
  input  logic                                   take_i
);

  localparam int IdxW = $clog2(MAX_BITS);
  localparam int NW   = $clog2(MAX_BITS + 1);
  localparam int StepW = $clog2(bfth_pkg::HashW);

  bfth_pkg::mod_state_e state_q, state_d;
  logic [StepW-1:0] step_q;
  logic [NW-1:0]    n_q, n_eff;
  logic             op_q;
  logic [bfth_pkg::NumHash-1:0][bfth_pkg::HashW-1:0] val_q;
  logic [bfth_pkg::NumHash-1:0][NW-1:0] rem_q, rem_d;
  logic [NW:0] trial [bfth_pkg::NumHash];

  always_comb begin
    if ({19'd0, filter_len_i} < 32'(bfth_pkg::MinBits)) begin
      n_eff = NW'(bfth_pkg::MinBits);
    end else if ({19'd0, filter_len_i} > 32'(MAX_BITS)) begin
      n_eff = NW'(MAX_BITS);
    end else begin
      n_eff = NW'(filter_len_i);
    end
  end

  // restoring step: remainder stays below n, shifted value below 2n
  always_comb begin
    for (int k = 0; k < bfth_pkg::NumHash; k++) begin
      trial[k] = {rem_q[k], val_q[k][bfth_pkg::HashW-1]};
      if (trial[k] >= {1'b0, n_q}) begin
        rem_d[k] = NW'(trial[k] - {1'b0, n_q});
      end else begin
        rem_d[k] = NW'(trial[k]);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfth_pkg::MS_IDLE: if (start_i) state_d = bfth_pkg::MS_RUN;
      bfth_pkg::MS_RUN:  if (step_q == StepW'(bfth_pkg::HashW - 1)) state_d = bfth_pkg::MS_HOLD;
      bfth_pkg::MS_HOLD: if (take_i) state_d = bfth_pkg::MS_IDLE;
      default:           state_d = bfth_pkg::MS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfth_pkg::MS_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == bfth_pkg::MS_RUN) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bfth_pkg::MS_IDLE && start_i) begin
      val_q <= hash_i;
      rem_q <= '0;
      n_q   <= n_eff;
      op_q  <= op_i;
    end else if (state_q == bfth_pkg::MS_RUN) begin
      for (int k = 0; k < bfth_pkg::NumHash; k++) begin
        val_q[k] <= val_q[k] << 1;
      end
      rem_q <= rem_d;
    end
  end

  assign ready_o     = (state_q == bfth_pkg::MS_IDLE);
  assign job_o.valid = (state_q == bfth_pkg::MS_HOLD);
  assign job_o.op    = op_q;

  always_comb begin
    for (int k = 0; k < bfth_pkg::NumHash; k++) begin
      idx_o[k] = rem_q[k][IdxW-1:0];
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_o.valid |-> (rem_q[0] < n_q) && (rem_q[1] < n_q) && (rem_q[2] < n_q))
    else $error("remainder not below bit count");

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ready_o)
    else $error("key end while remainder unit busy");

endmodule

FILE: src/bfth_store.sv
// Filter bit memory with clearing pass, bit set/test sequencer and result register.
`timescale 1ns / 1ps
module bfth_store #(
  parameter int MAX_BITS = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  bfth_pkg::job_ctl_t                     job_i,
  input  logic [bfth_pkg::NumHash-1:0][$clog2(MAX_BITS)-1:0] idx_i,
  output logic                                   take_o,
  output logic                                   clearing_o,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   was_query_o,
  output logic                                   might_contain_o
);

  localparam int IdxW = $clog2(MAX_BITS);

  bfth_pkg::store_state_e state_q, state_d;
  logic [1:0]      k_q;
  logic [IdxW-1:0] clr_q;
  logic            op_q;
  logic [bfth_pkg::NumHash-1:0][IdxW-1:0] idx_q;
  logic            all_q, rd_q, rd_pend_q;
  logic            out_valid_q, was_query_q, might_q;

  logic            mem [MAX_BITS];
  logic            mem_we, mem_re, mem_wdata;
  logic [IdxW-1:0] mem_addr;
  logic            load_out, result;

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = 1'b1;
    mem_addr  = idx_q[k_q];
    take_o    = 1'b0;
    load_out  = 1'b0;
    result    = all_q & (rd_pend_q ? rd_q : 1'b1);
    unique case (state_q)
      bfth_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = 1'b0;
        mem_addr  = clr_q;
        if (clr_q == IdxW'(MAX_BITS - 1)) state_d = bfth_pkg::ST_IDLE;
      end
      bfth_pkg::ST_IDLE: begin
        take_o = job_i.valid;
        if (job_i.valid) state_d = bfth_pkg::ST_ACCESS;
      end
      bfth_pkg::ST_ACCESS: begin
        mem_we = ~op_q;
        mem_re = op_q;
        if (k_q == 2'd2) state_d = bfth_pkg::ST_FINISH;
      end
      bfth_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = bfth_pkg::ST_IDLE;
        end
      end
      default: state_d = bfth_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfth_pkg::ST_CLEAR;
      clr_q       <= '0;
      k_q         <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= mem_re;
      if (state_q == bfth_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (take_o) begin
        k_q <= '0;
      end else if (state_q == bfth_pkg::ST_ACCESS) begin
        k_q <= k_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      idx_q <= idx_i;
      op_q  <= job_i.op;
      all_q <= 1'b1;
    end else if (rd_pend_q) begin
      all_q <= all_q & rd_q;
    end
    if (load_out) begin
      was_query_q <= op_q;
      might_q     <= op_q ? result : 1'b1;
    end
  end

  assign clearing_o      = (state_q == bfth_pkg::ST_CLEAR);
  assign out_valid_o     = out_valid_q;
  assign was_query_o     = was_query_q;
  assign might_contain_o = might_q;

  a_insert_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !was_query_q |-> might_q)
    else $error("insert acknowledged without might_contain");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !out_valid_q || !out_stall_i)
    else $error("result register overwritten while stalled");

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |-> state_q == bfth_pkg::ST_IDLE && !clearing_o)
    else $error("job taken outside idle");

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("read and write in one cycle");

endmodule

FILE: src/bloom_filter_three_hash_core.sv
// Top level: Bloom filter over byte-string keys with three running hashes.
// Key bytes are taken one per cycle while in_stall_o is low; the three hashes
// (DJB2, FNV-1a, shift-xor) are updated in the cycle a byte is taken. The final
// byte of a key hands the hashes to a bit-serial remainder unit, then the bit
// store does three single-port memory accesses and forms the result. Bytes of
// the next key keep streaming during that time; only its final byte waits until
// the remainder unit is free, so the remainder unit takes no new key before the
// bit store has taken the last one. After reset the filter memory is cleared
// one bit per cycle, and no byte is taken until that pass ends; filter length
// writes are taken at any time.
`timescale 1ns / 1ps
module bloom_filter_three_hash_core #(
  parameter int MAX_BITS = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bfth_pkg::CntW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [bfth_pkg::ByteW-1:0]  key_byte_i,
  input  logic                        key_last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        was_query_o,
  output logic                        might_contain_o
);

  localparam int IdxW = $clog2(MAX_BITS);

  logic [bfth_pkg::CntW-1:0] filter_len_q;
  logic in_accept, mod_start, mod_ready, take, clearing;
  logic [bfth_pkg::NumHash-1:0][bfth_pkg::HashW-1:0] hash;
  logic [bfth_pkg::NumHash-1:0][IdxW-1:0] idx;
  bfth_pkg::job_ctl_t job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_len_q <= bfth_pkg::BitCountReset;
    end else if (cfg_valid_i) begin
      filter_len_q <= cfg_data_i;
    end
  end

  assign in_stall_o = clearing || (key_last_i && !mod_ready);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign mod_start  = in_accept && key_last_i;

  bfth_hash u_hash (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .key_byte_i (key_byte_i),
    .key_last_i (key_last_i),
    .hash_o     (hash)
  );

  bfth_mod #(.MAX_BITS(MAX_BITS)) u_mod (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (mod_start),
    .op_i         (op_i),
    .filter_len_i (filter_len_q),
    .hash_i       (hash),
    .ready_o      (mod_ready),
    .job_o        (job),
    .idx_o        (idx),
    .take_i       (take)
  );

  bfth_store #(.MAX_BITS(MAX_BITS)) u_store (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_i           (job),
    .idx_i           (idx),
    .take_o          (take),
    .clearing_o      (clearing),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .was_query_o     (was_query_o),
    .might_contain_o (might_contain_o)
  );

endmodule
